// ----- src/srmff_pkg.sv -----
// ----------------------------------------------------------------------------
// srmff_pkg
// Shared types and codes for the sorted region map with first-fit placement.
// ----------------------------------------------------------------------------
package srmff_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int AW = 32;
  localparam int TW = 8;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_FIND  = 3'd1;
  localparam logic [2:0] CMD_CHECK = 3'd2;
  localparam logic [2:0] CMD_EDIT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [AW-1:0] ALL_ONES = '1;

  // one stored region
  typedef struct packed {
    logic [AW-1:0] base;
    logic [AW-1:0] limit;
    logic [TW-1:0] tag;
  } entry_t;

  // token that walks the cell row during a gap search or collision check
  typedef struct packed {
    logic          valid;
    logic          hit;
    logic [AW-1:0] off;
  } scan_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic          ins_en;
    logic          edit_en;
    logic          find_mode;
    entry_t        arg;
    logic [AW-1:0] size;
  } cell_ctl_t;

endpackage

// ----- src/srmff_cell.sv -----
// ----------------------------------------------------------------------------
// srmff_cell
// One table slot: holds a region, shifts right on ordered insert, and
// evaluates its own neighbor pair as the scan token passes.
// ----------------------------------------------------------------------------
module srmff_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  input  logic                     at_end,
  input  srmff_pkg::cell_ctl_t     ctl,
  input  srmff_pkg::entry_t        left_ent,
  input  logic                     left_gt,
  input  logic [srmff_pkg::AW-1:0] right_base,
  input  logic                     right_valid,
  input  srmff_pkg::scan_t         scan_in,
  output srmff_pkg::entry_t        ent,
  output logic                     gt,
  output srmff_pkg::scan_t         scan_out
);

  logic [srmff_pkg::AW-1:0] gap;
  logic                     hit;
  logic                     take_new;

  // slots at or beyond the insert point see a larger base
  assign gt       = valid && (ent.base > ctl.arg.base);
  assign take_new = !left_gt && (gt || at_end);

  assign gap = right_base - ent.limit;

  always_comb begin
    if (ctl.find_mode) begin
      hit = right_valid ? (gap >= ctl.size) : 1'b1;
    end else begin
      hit = right_valid && (right_base < ent.limit);
    end
  end

  // entry storage: shift from the left, load the new region, or edit the end
  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (left_gt) begin
        ent <= left_ent;
      end else if (take_new) begin
        ent <= ctl.arg;
      end
    end else if (ctl.edit_en && valid && (ent.tag == ctl.arg.tag)) begin
      ent.limit <= ctl.arg.limit;
    end
  end

  // pass the token on; first valid slot with a hit captures its end
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    if (scan_in.valid && !scan_in.hit && valid && hit) begin
      scan_out.hit <= 1'b1;
      scan_out.off <= ent.limit;
    end else begin
      scan_out.hit <= scan_in.hit;
      scan_out.off <= scan_in.off;
    end
  end

endmodule

// ----- src/sorted_region_map_first_fit_top.sv -----
// ----------------------------------------------------------------------------
// sorted_region_map_first_fit_top
// Sorted table of tagged address regions with ordered insert, first-fit
// gap placement, collision check, edit-by-tag and clear.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                       | handshake
//  ----------+-----------------------------------------------+-------------------
//  command   | command, start_addr, end_addr, size, tag_in    | start & !busy
//  result    | offset, collision, status                     | done, one cycle
//
//  For add, edit, clear, unused codes and find on an empty table, the result
//  beat shows on the cycle after the command beat.
//  Find space and check collisions walk a token down the row of
//  MAX_REGIONS cells, one cell a cycle; find then passes through a further
//  state that places the new region.
//  busy is high only after a scan command beat, until the result beat.
//  rst is synchronous and empties the table; the stored regions themselves
//  are not cleared and are read only below the fill count.
//  The result beat cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module sorted_region_map_first_fit_top #(
  parameter int MAX_REGIONS = srmff_pkg::MAX_REGIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               command,
  input  logic [srmff_pkg::AW-1:0] start_addr,
  input  logic [srmff_pkg::AW-1:0] end_addr,
  input  logic [srmff_pkg::AW-1:0] size,
  input  logic [srmff_pkg::TW-1:0] tag_in,
  output logic                     done,
  output logic [srmff_pkg::AW-1:0] offset,
  output logic                     collision,
  output logic [1:0]               status
);

  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUT  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]            count;
  logic                     full;
  logic                     accept;
  logic                     find_mode;
  logic [srmff_pkg::AW-1:0] size_l;
  logic [srmff_pkg::TW-1:0] tag_l;
  logic [srmff_pkg::AW-1:0] off_l;
  logic                     launch;

  srmff_pkg::cell_ctl_t     ctl;
  srmff_pkg::entry_t        ent   [MAX_REGIONS];
  logic                     gt    [MAX_REGIONS];
  srmff_pkg::scan_t         scan_q[MAX_REGIONS];
  logic [MAX_REGIONS-1:0]   valid;
  logic [MAX_REGIONS-1:0]   at_end;
  srmff_pkg::scan_t         scan_head;
  srmff_pkg::scan_t         scan_tail;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(MAX_REGIONS));

  // Slot occupancy follows straight from the fill count.
  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_occ
    assign valid[k]  = (count > CW'(k));
    assign at_end[k] = (count == CW'(k));
  end

  // Insert and edit are driven from the command beat in idle; the placement
  // after a gap search uses the latched search result.
  always_comb begin
    ctl           = '0;
    ctl.find_mode = find_mode;
    ctl.size      = size_l;
    launch        = 1'b0;
    if (state == S_PUT) begin
      ctl.arg.base  = off_l;
      ctl.arg.limit = off_l + size_l;
      ctl.arg.tag   = tag_l;
      ctl.ins_en    = (size_l != '0) && !full;
    end else begin
      ctl.arg.base  = start_addr;
      ctl.arg.limit = end_addr;
      ctl.arg.tag   = tag_in;
      if (accept) begin
        // the first cell tests its pair on the command beat: feed it live mode and size
        ctl.find_mode = (command == srmff_pkg::CMD_FIND);
        ctl.size      = size;
        case (command)
          srmff_pkg::CMD_ADD: begin
            ctl.ins_en = (start_addr != end_addr) && !full;
          end
          srmff_pkg::CMD_EDIT: begin
            ctl.edit_en = 1'b1;
          end
          srmff_pkg::CMD_FIND: begin
            launch = (count != '0);
          end
          srmff_pkg::CMD_CHECK: begin
            launch = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign scan_head.valid = launch;
  assign scan_head.hit   = 1'b0;
  assign scan_head.off   = '0;

  // Row of cells; each sees its left neighbor's entry for shifting and its
  // right neighbor's base for the pair tests.
  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
    srmff_pkg::entry_t        l_ent;
    logic                     l_gt;
    logic [srmff_pkg::AW-1:0] r_base;
    logic                     r_valid;
    srmff_pkg::scan_t         s_in;

    if (k == 0) begin : g_first
      assign l_ent = '0;
      assign l_gt  = 1'b0;
      assign s_in  = scan_head;
    end else begin : g_mid
      assign l_ent = ent[k-1];
      assign l_gt  = gt[k-1];
      assign s_in  = scan_q[k-1];
    end

    if (k == MAX_REGIONS - 1) begin : g_last
      assign r_base  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_base  = ent[k+1].base;
      assign r_valid = valid[k+1];
    end

    srmff_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid      (valid[k]),
      .at_end     (at_end[k]),
      .ctl        (ctl),
      .left_ent   (l_ent),
      .left_gt    (l_gt),
      .right_base (r_base),
      .right_valid(r_valid),
      .scan_in    (s_in),
      .ent        (ent[k]),
      .gt         (gt[k]),
      .scan_out   (scan_q[k])
    );
  end

  assign scan_tail = scan_q[MAX_REGIONS-1];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (launch) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_tail.valid) begin
          state_next = find_mode ? S_PUT : S_IDLE;
        end
      end
      S_PUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control: sequencer state, fill count and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (ctl.ins_en) begin
        count <= count + CW'(1);
      end
      if (accept && (command == srmff_pkg::CMD_CLEAR)) begin
        count <= '0;
      end
      if (accept && !launch) begin
        done <= 1'b1;
      end
      if ((state == S_SCAN) && scan_tail.valid && !find_mode) begin
        done <= 1'b1;
      end
      if (state == S_PUT) begin
        done <= 1'b1;
      end
    end
  end

  // Payload: latch search arguments and build the result beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      find_mode <= (command == srmff_pkg::CMD_FIND);
      size_l    <= size;
      tag_l     <= tag_in;
      offset    <= '0;
      collision <= 1'b0;
      status    <= srmff_pkg::ST_OK;
      case (command)
        srmff_pkg::CMD_ADD: begin
          if (start_addr == end_addr) begin
            status <= srmff_pkg::ST_EMPTY;
          end else if (full) begin
            status <= srmff_pkg::ST_FULL;
          end
        end
        srmff_pkg::CMD_FIND: begin
          if (count == '0) begin
            offset <= srmff_pkg::ALL_ONES;
          end
        end
        default: begin
        end
      endcase
    end
    if ((state == S_SCAN) && scan_tail.valid) begin
      off_l     <= scan_tail.off;
      collision <= !find_mode && scan_tail.hit;
    end
    if (state == S_PUT) begin
      offset <= off_l;
      if (size_l == '0) begin
        status <= srmff_pkg::ST_EMPTY;
      end else if (full) begin
        status <= srmff_pkg::ST_FULL;
      end else begin
        status <= srmff_pkg::ST_OK;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS))
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1)) || (count == '0))
    else $error("fill count moved by more than one");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_tail.valid |-> (state == S_SCAN))
    else $error("scan token left the row outside a scan");

  a_collision_clean: assert property (@(posedge clk) disable iff (rst)
    (done && collision) |-> (offset == '0) && (status == srmff_pkg::ST_OK))
    else $error("collision beat carries offset or status");

  a_find_finds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && scan_tail.valid && find_mode) |-> scan_tail.hit)
    else $error("gap search ended without a placement");

endmodule
